// ----- rtl/p2sca_pkg.sv -----
// p2sca_pkg: constants, codes and helpers for the power-of-two size class allocator
// no dependencies
`default_nettype none
package p2sca_pkg;

    localparam int MAX_BLOCKS     = 64;
    localparam int MIN_BLOCK_SIZE = 8;
    localparam int ADDR_BITS      = 16;
    localparam int IDX_BITS       = $clog2(MAX_BLOCKS);
    localparam int SIZE_BITS      = 17;
    localparam int LOG_BITS       = 5;
    localparam logic [LOG_BITS-1:0] MIN_LOG = LOG_BITS'($clog2(MIN_BLOCK_SIZE));
    localparam logic [SIZE_BITS:0] POOL_CAP = (SIZE_BITS+1)'(1) << ADDR_BITS;

    localparam logic [1:0] ENT_EMPTY = 2'd0;
    localparam logic [1:0] ENT_ALLOC = 2'd1;
    localparam logic [1:0] ENT_FREE  = 2'd2;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_OOM     = 2'd1,
        STAT_UNKNOWN = 2'd2,
        STAT_FULL    = 2'd3
    } status_t;

    // ceil log2 of a 17-bit request, floored at the minimum block log
    function automatic logic [LOG_BITS-1:0] size_log(input logic [SIZE_BITS-1:0] req);
        logic [LOG_BITS-1:0] k;
        k = '0;
        for (int b = 0; b <= SIZE_BITS; b++) begin
            if (k == LOG_BITS'(b) && ((SIZE_BITS+1)'(1) << b) < {1'b0, req}) begin
                k = LOG_BITS'(b + 1);
            end
        end
        return (k < MIN_LOG) ? MIN_LOG : k;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/pow2_size_class_allocator.sv -----
// pow2_size_class_allocator: power-of-two segregated fit block allocator
// depends on p2sca_pkg
//
// channel | dir | handshake          | word
// s_      | in  | s_valid / s_ready  | func, request_size, block_address
// m_      | out | m_valid / m_ready  | granted_address, granted_size, status
// cfg     | in  | cfg_we             | cfg_wdata (pool_size)
//
// a new word is accepted only in the idle state, after the scan and decide states: the scan
// sweeps the block table through its single registered read port, the decide state
// writes back the chosen entry and loads the result, and the idle state takes a word
// reset clears the block table with a pass over every entry, s_ready low meanwhile
// a new word is taken while the previous result waits on m_; the next result
// stalls in the decide state until the output register is free
`default_nettype none
module pow2_size_class_allocator (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               cfg_we,
    input  wire [p2sca_pkg::SIZE_BITS-1:0]    cfg_wdata,
    input  wire                               s_valid,
    output logic                              s_ready,
    input  wire                               s_func,
    input  wire [p2sca_pkg::SIZE_BITS-1:0]    s_request_size,
    input  wire [p2sca_pkg::ADDR_BITS-1:0]    s_block_address,
    output logic                              m_valid,
    input  wire                               m_ready,
    output logic [p2sca_pkg::ADDR_BITS-1:0]   m_granted_address,
    output logic [p2sca_pkg::SIZE_BITS-1:0]   m_granted_size,
    output logic [1:0]                        m_status
);
    import p2sca_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR  = 4'b0001,
        S_IDLE   = 4'b0010,
        S_SCAN   = 4'b0100,
        S_DECIDE = 4'b1000
    } state_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] offset;
        logic [LOG_BITS-1:0]  lg;
        logic [1:0]           st;
    } entry_t;

    // block table: one memory, registered read
    entry_t table_mem [MAX_BLOCKS];
    entry_t rd_data_reg;
    logic                 mem_we;
    logic [IDX_BITS-1:0]  mem_waddr;
    entry_t               mem_wdata;
    logic [IDX_BITS-1:0]  rd_addr;

    state_t state_reg, state_next;
    logic [IDX_BITS:0]    cnt_reg, cnt_next;     // read address counter
    logic [IDX_BITS:0]    chk_reg, chk_next;     // index of entry in rd_data_reg
    logic                 rd_ok_reg, rd_ok_next;

    logic [SIZE_BITS-1:0] pool_reg;
    logic [SIZE_BITS-1:0] nfo_reg, nfo_next;
    logic [SIZE_BITS-1:0] used_reg, used_next;

    // captured request
    logic                 func_reg;
    logic [LOG_BITS-1:0]  lg_reg;
    logic [ADDR_BITS-1:0] addr_reg;

    // scan results
    logic                 best_v_reg, best_v_next;
    logic [IDX_BITS-1:0]  best_i_reg, best_i_next;
    logic [ADDR_BITS-1:0] best_off_reg, best_off_next;
    logic [LOG_BITS-1:0]  best_lg_reg, best_lg_next;
    logic                 emp_v_reg, emp_v_next;
    logic [IDX_BITS-1:0]  emp_i_reg, emp_i_next;

    logic                 mv_reg;
    logic [ADDR_BITS-1:0] ma_reg;
    logic [SIZE_BITS-1:0] ms_reg;
    logic [1:0]           mst_reg;
    logic                 out_free;
    logic [SIZE_BITS:0]   blk_size, eff_pool, need;

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = mv_reg;
    assign m_granted_address = ma_reg;
    assign m_granted_size    = ms_reg;
    assign m_status          = mst_reg;
    assign out_free = !mv_reg || m_ready;
    assign rd_addr  = cnt_reg[IDX_BITS-1:0];

    assign blk_size = (SIZE_BITS+1)'(1) << lg_reg;
    assign eff_pool = ({1'b0, pool_reg} > POOL_CAP) ? POOL_CAP : {1'b0, pool_reg};
    assign need     = {1'b0, used_reg} + blk_size;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= table_mem[rd_addr];
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        chk_next      = chk_reg;
        rd_ok_next    = 1'b0;
        nfo_next      = nfo_reg;
        used_next     = used_reg;
        best_v_next   = best_v_reg;
        best_i_next   = best_i_reg;
        best_off_next = best_off_reg;
        best_lg_next  = best_lg_reg;
        emp_v_next    = emp_v_reg;
        emp_i_next    = emp_i_reg;
        mem_we        = 1'b0;
        mem_waddr     = rd_addr;
        mem_wdata     = '{offset: '0, lg: '0, st: ENT_EMPTY};
        unique case (state_reg)
            S_CLEAR: begin
                mem_we   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (IDX_BITS+1)'(MAX_BLOCKS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    state_next  = S_SCAN;
                    cnt_next    = '0;
                    best_v_next = 1'b0;
                    emp_v_next  = 1'b0;
                end
            end
            S_SCAN: begin
                // issue read at cnt, examine the one read last cycle
                if (!cnt_reg[IDX_BITS]) begin
                    rd_ok_next = 1'b1;
                    chk_next   = cnt_reg;
                    cnt_next   = cnt_reg + 1'b1;
                end
                if (rd_ok_reg) begin
                    if (func_reg) begin
                        if (!best_v_reg && rd_data_reg.st == ENT_ALLOC &&
                            rd_data_reg.offset == addr_reg) begin
                            best_v_next  = 1'b1;
                            best_i_next  = chk_reg[IDX_BITS-1:0];
                            best_lg_next = rd_data_reg.lg;
                        end
                    end else if (rd_data_reg.st == ENT_FREE && rd_data_reg.lg == lg_reg) begin
                        if (!best_v_reg || rd_data_reg.offset < best_off_reg) begin
                            best_v_next   = 1'b1;
                            best_i_next   = chk_reg[IDX_BITS-1:0];
                            best_off_next = rd_data_reg.offset;
                        end
                    end else if (rd_data_reg.st == ENT_EMPTY && !emp_v_reg) begin
                        emp_v_next = 1'b1;
                        emp_i_next = chk_reg[IDX_BITS-1:0];
                    end
                end else if (cnt_reg[IDX_BITS]) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                    if (func_reg) begin
                        if (best_v_reg) begin
                            mem_we    = 1'b1;
                            mem_waddr = best_i_reg;
                            mem_wdata = '{offset: addr_reg, lg: best_lg_reg, st: ENT_FREE};
                        end
                    end else if (best_v_reg) begin
                        mem_we    = 1'b1;
                        mem_waddr = best_i_reg;
                        mem_wdata = '{offset: best_off_reg, lg: lg_reg, st: ENT_ALLOC};
                    end else if (need <= eff_pool && emp_v_reg) begin
                        mem_we    = 1'b1;
                        mem_waddr = emp_i_reg;
                        mem_wdata = '{offset: nfo_reg[ADDR_BITS-1:0], lg: lg_reg,
                                      st: ENT_ALLOC};
                        nfo_next  = nfo_reg + blk_size[SIZE_BITS-1:0];
                        used_next = need[SIZE_BITS-1:0];
                    end
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
            rd_ok_reg <= 1'b0;
            pool_reg  <= SIZE_BITS'(65536);
            nfo_reg   <= '0;
            used_reg  <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rd_ok_reg <= rd_ok_next;
            nfo_reg   <= nfo_next;
            used_reg  <= used_next;
            if (cfg_we) begin
                pool_reg <= cfg_wdata;
            end
            if (state_reg == S_DECIDE && out_free) begin
                mv_reg <= 1'b1;
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        chk_reg      <= chk_next;
        best_v_reg   <= best_v_next;
        best_i_reg   <= best_i_next;
        best_off_reg <= best_off_next;
        best_lg_reg  <= best_lg_next;
        emp_v_reg    <= emp_v_next;
        emp_i_reg    <= emp_i_next;
        if (s_valid && s_ready) begin
            func_reg <= s_func;
            lg_reg   <= size_log(s_request_size);
            addr_reg <= s_block_address;
        end
        if (state_reg == S_DECIDE && out_free) begin
            if (func_reg) begin
                ma_reg  <= best_v_reg ? addr_reg : '0;
                ms_reg  <= best_v_reg ? SIZE_BITS'(SIZE_BITS'(1) << best_lg_reg) : '0;
                mst_reg <= best_v_reg ? STAT_OK : STAT_UNKNOWN;
            end else if (best_v_reg) begin
                ma_reg  <= best_off_reg;
                ms_reg  <= blk_size[SIZE_BITS-1:0];
                mst_reg <= STAT_OK;
            end else if (need > eff_pool) begin
                ma_reg  <= '0;
                ms_reg  <= '0;
                mst_reg <= STAT_OOM;
            end else if (!emp_v_reg) begin
                ma_reg  <= '0;
                ms_reg  <= '0;
                mst_reg <= STAT_FULL;
            end else begin
                ma_reg  <= nfo_reg[ADDR_BITS-1:0];
                ms_reg  <= blk_size[SIZE_BITS-1:0];
                mst_reg <= STAT_OK;
            end
        end
    end

`ifndef SYNTHESIS
    // no word taken outside the idle state: not during the clearing pass, the scan or the decide state
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_ready)
        else $error("word accepted while busy");
    // result is raised only from the decide state
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(mv_reg) |-> $past(state_reg == S_DECIDE))
        else $error("result without decision");
    // used total never shrinks
    a_used_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (used_reg >= $past(used_reg)))
        else $error("used total shrank");
    // error results carry zero size and zero address
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (mv_reg && mst_reg != STAT_OK) |-> (ms_reg == '0 && ma_reg == '0))
        else $error("error result with payload");
`endif

endmodule
`default_nettype wire
